[hw/rtl/damped_wave_grid_step_defines.svh]
// ----------------------------------------------------------------------------
// Damped wave grid step assertion macros
// Shared concurrent assertion helpers clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DAMPED_WAVE_GRID_STEP_DEFINES_SVH
`define DAMPED_WAVE_GRID_STEP_DEFINES_SVH

// The expression must hold at every clock edge.
`define DWGS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define DWGS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hw/rtl/dwgs_pkg.sv]
// ----------------------------------------------------------------------------
// Damped wave grid step package
// Grid geometry, value formats, codes and memory request types.
// ----------------------------------------------------------------------------
`default_nettype none

package dwgs_pkg;

    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;
    localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int COL_CW      = $clog2(GRID_WIDTH);
    localparam int ROW_CW      = $clog2(GRID_HEIGHT);
    localparam int ROW_W       = 6;
    localparam int COL_W       = 6;
    localparam int VAL_W       = 18;
    localparam int DAMP_W      = 16;
    localparam int PHASE_W     = 3;

    localparam logic signed [VAL_W+1:0] VAL_MAX = (VAL_W+2)'(131071);
    localparam logic signed [VAL_W+1:0] VAL_MIN = -(VAL_W+2)'(131072);

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_STEP  = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_P1,
        S_P2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                    re;
        logic [ADDR_W-1:0]       addr_a;
        logic [ADDR_W-1:0]       addr_b;
        logic                    we;
        logic [ADDR_W-1:0]       waddr;
        logic signed [VAL_W-1:0] wdata;
    } t_hreq;

    typedef struct packed {
        logic                    re;
        logic [ADDR_W-1:0]       raddr;
        logic                    we;
        logic [ADDR_W-1:0]       waddr;
        logic signed [VAL_W-1:0] wdata;
    } t_vreq;

    function automatic logic signed [VAL_W+1:0] ext2(input logic signed [VAL_W-1:0] x);
        return {{2{x[VAL_W-1]}}, x};
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [VAL_W+1:0] x);
        logic signed [VAL_W-1:0] res;
        if (x > VAL_MAX) begin
            res = VAL_MAX[VAL_W-1:0];
        end else if (x < VAL_MIN) begin
            res = VAL_MIN[VAL_W-1:0];
        end else begin
            res = x[VAL_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/dwgs_hmem.sv]
// ----------------------------------------------------------------------------
// Height memory
// Two registered read ports and one write port over the height grid.
// ----------------------------------------------------------------------------
`default_nettype none

module dwgs_hmem (
    input  wire logic                                i_clk,
    input  wire dwgs_pkg::t_hreq                     i_req,
    output logic signed [dwgs_pkg::VAL_W-1:0]        o_rd_a,
    output logic signed [dwgs_pkg::VAL_W-1:0]        o_rd_b
);

    logic signed [dwgs_pkg::VAL_W-1:0] mem [dwgs_pkg::CELLS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rd_a <= mem[i_req.addr_a];
            o_rd_b <= mem[i_req.addr_b];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/dwgs_vmem.sv]
// ----------------------------------------------------------------------------
// Velocity memory
// One registered read port and one write port over the velocity grid.
// ----------------------------------------------------------------------------
`default_nettype none

module dwgs_vmem (
    input  wire logic                                i_clk,
    input  wire dwgs_pkg::t_vreq                     i_req,
    output logic signed [dwgs_pkg::VAL_W-1:0]        o_rd
);

    logic signed [dwgs_pkg::VAL_W-1:0] mem [dwgs_pkg::CELLS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rd <= mem[i_req.raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/dwgs_ctrl.sv]
// ----------------------------------------------------------------------------
// Damped wave grid step sequencer
// Handles requests, the velocity clearing pass and both sweeps of a step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "damped_wave_grid_step_defines.svh"

module dwgs_ctrl (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [dwgs_pkg::DAMP_W-1:0]         i_damping,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire dwgs_pkg::t_action                   i_action,
    input  wire logic [dwgs_pkg::ROW_W-1:0]          i_row,
    input  wire logic [dwgs_pkg::COL_W-1:0]          i_col,
    input  wire logic signed [dwgs_pkg::VAL_W-1:0]   i_height_in,
    input  wire logic                                i_m_tready,
    output logic                                     o_m_tvalid,
    output logic signed [dwgs_pkg::VAL_W-1:0]        o_height_out,
    output logic                                     o_step_done,
    output dwgs_pkg::t_hreq                          o_hreq,
    input  wire logic signed [dwgs_pkg::VAL_W-1:0]   i_h_rd_a,
    input  wire logic signed [dwgs_pkg::VAL_W-1:0]   i_h_rd_b,
    output dwgs_pkg::t_vreq                          o_vreq,
    input  wire logic signed [dwgs_pkg::VAL_W-1:0]   i_v_rd
);

    localparam int AW = dwgs_pkg::ADDR_W;
    localparam int VW = dwgs_pkg::VAL_W;
    localparam logic [AW-1:0] W_A = AW'(dwgs_pkg::GRID_WIDTH);

    dwgs_pkg::t_state r_state, n_state;
    logic [dwgs_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [AW-1:0] r_idx, n_idx;
    logic [dwgs_pkg::COL_CW-1:0] r_col, n_col;
    logic [dwgs_pkg::ROW_CW-1:0] r_row, n_row;
    logic signed [VW+1:0] r_sum, n_sum;
    logic signed [VW-1:0] r_v, n_v;
    logic r_inside, n_inside;
    logic r_out_valid, n_out_valid;
    logic signed [VW-1:0] r_out_height, n_out_height;
    logic r_out_step, n_out_step;

    logic [AW-1:0] w_addr;
    logic w_inside;
    logic w_last_cell;
    logic signed [VW+dwgs_pkg::DAMP_W:0] w_prod;
    logic signed [VW-1:0] w_damped;

    assign w_addr = AW'(AW'(i_row) * W_A + AW'(i_col));
    assign w_inside = ({1'b0, i_row} < (dwgs_pkg::ROW_W+1)'(dwgs_pkg::GRID_HEIGHT))
                   && ({1'b0, i_col} < (dwgs_pkg::COL_W+1)'(dwgs_pkg::GRID_WIDTH));
    assign w_last_cell = (r_row == dwgs_pkg::ROW_CW'(dwgs_pkg::GRID_HEIGHT - 2))
                      && (r_col == dwgs_pkg::COL_CW'(dwgs_pkg::GRID_WIDTH - 2));
    assign w_prod = r_v * $signed({1'b0, i_damping});
    assign w_damped = w_prod[dwgs_pkg::DAMP_W +: VW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dwgs_pkg::S_CLEAR;
            r_phase     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col        <= n_col;
        r_row        <= n_row;
        r_sum        <= n_sum;
        r_v          <= n_v;
        r_inside     <= n_inside;
        r_out_height <= n_out_height;
        r_out_step   <= n_out_step;
    end

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_idx        = r_idx;
        n_col        = r_col;
        n_row        = r_row;
        n_sum        = r_sum;
        n_v          = r_v;
        n_inside     = r_inside;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_height = r_out_height;
        n_out_step   = r_out_step;
        o_hreq       = '0;
        o_vreq       = '0;
        o_s_tready   = 1'b0;
        case (r_state)
            dwgs_pkg::S_CLEAR: begin
                o_vreq.we    = 1'b1;
                o_vreq.waddr = r_idx;
                if (r_idx == AW'(dwgs_pkg::CELLS - 1)) begin
                    n_idx   = '0;
                    n_state = dwgs_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            dwgs_pkg::S_IDLE: begin
                o_s_tready = !r_out_valid || i_m_tready;
                if (o_s_tready && i_s_tvalid) begin
                    case (i_action)
                        dwgs_pkg::ACT_WRITE: begin
                            o_hreq.we    = w_inside;
                            o_hreq.waddr = w_addr;
                            o_hreq.wdata = i_height_in;
                        end
                        dwgs_pkg::ACT_STEP: begin
                            n_state = dwgs_pkg::S_P1;
                            n_phase = '0;
                            n_idx   = W_A + 1'b1;
                            n_col   = dwgs_pkg::COL_CW'(1);
                            n_row   = dwgs_pkg::ROW_CW'(1);
                        end
                        dwgs_pkg::ACT_READ: begin
                            o_hreq.re     = 1'b1;
                            o_hreq.addr_a = w_addr;
                            o_hreq.addr_b = w_addr;
                            n_inside      = w_inside;
                            n_state       = dwgs_pkg::S_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            dwgs_pkg::S_READ: begin
                n_out_valid  = 1'b1;
                n_out_height = r_inside ? i_h_rd_a : '0;
                n_out_step   = 1'b0;
                n_state      = dwgs_pkg::S_IDLE;
            end
            dwgs_pkg::S_P1: begin
                n_phase = r_phase + 1'b1;
                case (r_phase)
                    3'd0: begin
                        o_hreq.re     = 1'b1;
                        o_hreq.addr_a = r_idx - W_A;
                        o_hreq.addr_b = r_idx + W_A;
                    end
                    3'd1: begin
                        o_hreq.re     = 1'b1;
                        o_hreq.addr_a = r_idx - 1'b1;
                        o_hreq.addr_b = r_idx + 1'b1;
                        n_sum = dwgs_pkg::ext2(i_h_rd_a) + dwgs_pkg::ext2(i_h_rd_b);
                    end
                    3'd2: begin
                        o_hreq.re     = 1'b1;
                        o_hreq.addr_a = r_idx;
                        o_hreq.addr_b = r_idx;
                        o_vreq.re     = 1'b1;
                        o_vreq.raddr  = r_idx;
                        n_sum = r_sum + dwgs_pkg::ext2(i_h_rd_a) + dwgs_pkg::ext2(i_h_rd_b);
                    end
                    3'd3: begin
                        n_v = dwgs_pkg::sat_val(dwgs_pkg::ext2(i_v_rd) + (r_sum >>> 2)
                                                - dwgs_pkg::ext2(i_h_rd_a));
                    end
                    3'd4: begin
                        o_vreq.we    = 1'b1;
                        o_vreq.waddr = r_idx;
                        o_vreq.wdata = w_damped;
                        n_phase      = '0;
                        if (w_last_cell) begin
                            n_state = dwgs_pkg::S_P2;
                            n_idx   = '0;
                        end else if (r_col == dwgs_pkg::COL_CW'(dwgs_pkg::GRID_WIDTH - 2)) begin
                            n_col = dwgs_pkg::COL_CW'(1);
                            n_row = r_row + 1'b1;
                            n_idx = r_idx + AW'(3);
                        end else begin
                            n_col = r_col + 1'b1;
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    default: begin
                        n_phase = '0;
                    end
                endcase
            end
            dwgs_pkg::S_P2: begin
                if (r_phase == '0) begin
                    o_hreq.re     = 1'b1;
                    o_hreq.addr_a = r_idx;
                    o_hreq.addr_b = r_idx;
                    o_vreq.re     = 1'b1;
                    o_vreq.raddr  = r_idx;
                    n_phase       = dwgs_pkg::PHASE_W'(1);
                end else begin
                    o_hreq.we    = 1'b1;
                    o_hreq.waddr = r_idx;
                    o_hreq.wdata = dwgs_pkg::sat_val(dwgs_pkg::ext2(i_h_rd_a)
                                                     + dwgs_pkg::ext2(i_v_rd));
                    n_phase      = '0;
                    if (r_idx == AW'(dwgs_pkg::CELLS - 1)) begin
                        n_state = dwgs_pkg::S_DONE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            dwgs_pkg::S_DONE: begin
                if (!r_out_valid) begin
                    n_out_valid  = 1'b1;
                    n_out_height = '0;
                    n_out_step   = 1'b1;
                    n_state      = dwgs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dwgs_pkg::S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_height_out = r_out_height;
    assign o_step_done  = r_out_step;

    `DWGS_ASSERT_IMPLIES(a_read_slot_free, r_state == dwgs_pkg::S_READ, !r_out_valid, "read data landed on a full output register")
    `DWGS_ASSERT_IMPLIES(a_no_hwrite_p1, r_state == dwgs_pkg::S_P1, !o_hreq.we, "height written during the velocity sweep")
    `DWGS_ASSERT_IMPLIES(a_interior_only, (r_state == dwgs_pkg::S_P1) && o_vreq.we, (r_col != '0) && (r_row != '0) && (r_col != dwgs_pkg::COL_CW'(dwgs_pkg::GRID_WIDTH - 1)), "border velocity written")
    `DWGS_ASSERT_IMPLIES(a_busy_not_ready, r_state != dwgs_pkg::S_IDLE, !o_s_tready, "request taken while busy")

endmodule

`default_nettype wire

[hw/rtl/damped_wave_grid_step.sv]
// ----------------------------------------------------------------------------
// Damped wave grid step
// Height-field ripple engine with height and velocity grids in memory.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: s_tuser carries the action (write,
// step, read), s_tdata the cell row, column and the height to write.
// Results leave on the m_ stream: m_tdata carries the height read back,
// m_tuser the step done flag. A write gives no result.
// A write is done as the request is taken. A read passes through the read
// register of the height memory and then the output register. A step
// updates the velocity of each interior cell, limited by the two read
// ports of the height memory, then adds each velocity to its height over
// all cells. One request is worked on at a time. After reset the velocity
// memory is cleared cell by cell, during which no request is taken; the
// damping register resets to 65535. The user must write it over the APB
// port only while no request is in progress; the block does not enforce it.
// A result waits in an output register while the receiver stalls; the next
// request is taken once that register is being emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module damped_wave_grid_step (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [5:0] row, [11:6] col, [29:12] height_in, [31:30] zero
    input  wire logic [31:0] s_tdata,
    // [1:0] action
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [17:0] height_out, [23:18] zero
    output logic [23:0]      m_tdata,
    // [0] step_done
    output logic [0:0]       m_tuser
);

    logic [dwgs_pkg::DAMP_W-1:0] r_damping;
    dwgs_pkg::t_hreq w_hreq;
    dwgs_pkg::t_vreq w_vreq;
    logic signed [dwgs_pkg::VAL_W-1:0] w_h_rd_a, w_h_rd_b, w_v_rd, w_height_out;
    logic w_step_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damping <= '1;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_damping <= pwdata[dwgs_pkg::DAMP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {16'd0, r_damping} : 32'd0;

    dwgs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_damping    (r_damping),
        .i_s_tvalid   (s_tvalid),
        .o_s_tready   (s_tready),
        .i_action     (dwgs_pkg::t_action'(s_tuser)),
        .i_row        (s_tdata[5:0]),
        .i_col        (s_tdata[11:6]),
        .i_height_in  (s_tdata[29:12]),
        .i_m_tready   (m_tready),
        .o_m_tvalid   (m_tvalid),
        .o_height_out (w_height_out),
        .o_step_done  (w_step_done),
        .o_hreq       (w_hreq),
        .i_h_rd_a     (w_h_rd_a),
        .i_h_rd_b     (w_h_rd_b),
        .o_vreq       (w_vreq),
        .i_v_rd       (w_v_rd)
    );

    dwgs_hmem u_hmem (
        .i_clk  (i_clk),
        .i_req  (w_hreq),
        .o_rd_a (w_h_rd_a),
        .o_rd_b (w_h_rd_b)
    );

    dwgs_vmem u_vmem (
        .i_clk (i_clk),
        .i_req (w_vreq),
        .o_rd  (w_v_rd)
    );

    assign m_tdata = {6'd0, w_height_out};
    assign m_tuser = w_step_done;

endmodule

`default_nettype wire

[tb/damped_wave_grid_step_tb.sv]
// ----------------------------------------------------------------------------
// Damped wave grid step testbench
// Fills the whole height grid, then drives a table of directed requests and
// random requests under several damping settings, with random idling on both
// streams. A predictor keeps its own height and velocity grids and checks
// every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module damped_wave_grid_step_tb;

    localparam logic [1:0] ACT_IGNORED = 2'd3;
    localparam logic [2:0] REG_DAMPING = 3'd0;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int MAX_STEPS = 14;
    localparam logic signed [dwgs_pkg::VAL_W-1:0] H_MAX = 18'sd131071;
    localparam logic signed [dwgs_pkg::VAL_W-1:0] H_MIN = 18'sh20000;

    typedef struct {
        logic signed [dwgs_pkg::VAL_W-1:0] height;
        logic                              done;
    } t_ripple_result;

    typedef struct {
        logic [1:0]                        act;
        logic [dwgs_pkg::ROW_W-1:0]        row;
        logic [dwgs_pkg::COL_W-1:0]        col;
        logic signed [dwgs_pkg::VAL_W-1:0] height;
        logic                              typed;
        logic signed [dwgs_pkg::VAL_W-1:0] exp_height;
        logic                              exp_done;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    logic signed [dwgs_pkg::VAL_W-1:0] model_height [dwgs_pkg::CELLS];
    logic signed [dwgs_pkg::VAL_W-1:0] model_velocity [dwgs_pkg::CELLS];
    logic [dwgs_pkg::DAMP_W-1:0]       model_damping = 16'hFFFF;
    t_ripple_result                    pending_results [$];
    int                                error_count = 0;
    int                                cycle_count = 0;
    int                                steps_run = 0;
    bit                                calm = 1'b0;

    t_directed_row directed [16] = '{
        '{dwgs_pkg::ACT_WRITE, 6'd0,  6'd0,  H_MAX,   1'b0, '0,      1'b0},
        '{dwgs_pkg::ACT_READ,  6'd0,  6'd0,  '0,      1'b1, H_MAX,   1'b0},
        '{dwgs_pkg::ACT_WRITE, 6'd63, 6'd63, H_MIN,   1'b0, '0,      1'b0},
        '{dwgs_pkg::ACT_READ,  6'd63, 6'd63, '0,      1'b1, H_MIN,   1'b0},
        '{dwgs_pkg::ACT_WRITE, 6'd5,  6'd7,  -18'sd1, 1'b0, '0,      1'b0},
        '{dwgs_pkg::ACT_READ,  6'd5,  6'd7,  '0,      1'b1, -18'sd1, 1'b0},
        '{dwgs_pkg::ACT_WRITE, 6'd0,  6'd63, '0,      1'b0, '0,      1'b0},
        '{dwgs_pkg::ACT_READ,  6'd0,  6'd63, '0,      1'b1, '0,      1'b0},
        '{ACT_IGNORED,         6'd1,  6'd1,  H_MAX,   1'b0, '0,      1'b0},
        '{dwgs_pkg::ACT_READ,  6'd1,  6'd1,  '0,      1'b0, '0,      1'b0},
        '{dwgs_pkg::ACT_STEP,  6'd0,  6'd0,  '0,      1'b1, '0,      1'b1},
        '{dwgs_pkg::ACT_READ,  6'd1,  6'd1,  '0,      1'b0, '0,      1'b0},
        '{dwgs_pkg::ACT_READ,  6'd2,  6'd3,  '0,      1'b0, '0,      1'b0},
        '{dwgs_pkg::ACT_READ,  6'd63, 6'd0,  '0,      1'b0, '0,      1'b0},
        '{dwgs_pkg::ACT_STEP,  6'd63, 6'd63, '0,      1'b1, '0,      1'b1},
        '{dwgs_pkg::ACT_READ,  6'd3,  6'd4,  '0,      1'b0, '0,      1'b0}
    };
    logic [dwgs_pkg::DAMP_W-1:0] phase_damping [5] = '{16'h0000, 16'h8000, 16'hFFFF,
                                                        16'h0001, 16'hFFFF};

    damped_wave_grid_step u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic signed [dwgs_pkg::VAL_W-1:0] clamp_height(input longint x);
        if (x > 131071) begin
            return H_MAX;
        end
        if (x < -131072) begin
            return H_MIN;
        end
        return dwgs_pkg::VAL_W'(x);
    endfunction

    function automatic void ripple_step();
        int     idx;
        longint sum;
        longint vel;
        for (int r = 1; r < dwgs_pkg::GRID_HEIGHT - 1; r++) begin
            for (int c = 1; c < dwgs_pkg::GRID_WIDTH - 1; c++) begin
                idx = r * dwgs_pkg::GRID_WIDTH + c;
                sum = longint'(model_height[idx - dwgs_pkg::GRID_WIDTH]) +
                      longint'(model_height[idx + dwgs_pkg::GRID_WIDTH]) +
                      longint'(model_height[idx - 1]) + longint'(model_height[idx + 1]);
                vel = longint'(model_velocity[idx]) + (sum >>> 2) -
                      longint'(model_height[idx]);
                vel = longint'(clamp_height(vel));
                model_velocity[idx] =
                    dwgs_pkg::VAL_W'((vel * longint'(model_damping)) >>> 16);
            end
        end
        for (int i = 0; i < dwgs_pkg::CELLS; i++) begin
            model_height[i] = clamp_height(longint'(model_height[i]) +
                                           longint'(model_velocity[i]));
        end
    endfunction

    // Updates the grids for one taken request and returns whether it gives a result.
    function automatic bit ripple_predict(input logic [1:0] act,
                                          input logic [dwgs_pkg::ROW_W-1:0] row,
                                          input logic [dwgs_pkg::COL_W-1:0] col,
                                          input logic signed [dwgs_pkg::VAL_W-1:0] h,
                                          output t_ripple_result res);
        int idx;
        idx = int'(row) * dwgs_pkg::GRID_WIDTH + int'(col);
        res.height = '0;
        res.done = 1'b0;
        case (act)
            dwgs_pkg::ACT_WRITE: begin
                model_height[idx] = h;
                return 1'b0;
            end
            dwgs_pkg::ACT_STEP: begin
                ripple_step();
                res.done = 1'b1;
                return 1'b1;
            end
            dwgs_pkg::ACT_READ: begin
                res.height = model_height[idx];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic send_request(input logic [1:0] act,
                                input logic [dwgs_pkg::ROW_W-1:0] row,
                                input logic [dwgs_pkg::COL_W-1:0] col,
                                input logic signed [dwgs_pkg::VAL_W-1:0] h,
                                input bit typed, input t_ripple_result typed_res);
        t_ripple_result res;
        bit             gives;
        if (!calm && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {2'b00, h, col, row};
        do @(posedge i_clk); while (!s_tready);
        gives = ripple_predict(act, row, col, h, res);
        if (gives) begin
            pending_results.push_back(typed ? typed_res : res);
        end
        if (act == dwgs_pkg::ACT_STEP) begin
            steps_run++;
        end
    endtask

    task automatic release_stream();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_damping(input logic [dwgs_pkg::DAMP_W-1:0] value);
        wait (pending_results.size() == 0);
        repeat (8) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_DAMPING;
        pwdata <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        model_damping = value;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
    end

    always @(posedge i_clk) begin
        t_ripple_result want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("damped_wave_grid_step_tb: errors");
            $finish;
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: height %0d done %0b",
                         $time, $signed(m_tdata[dwgs_pkg::VAL_W-1:0]), m_tuser[0]);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[dwgs_pkg::VAL_W-1:0] !== want.height ||
                    m_tuser[0] !== want.done) begin
                    $display("%0t: mismatch: expected height %0d done %0b, got %0d done %0b",
                             $time, want.height, want.done,
                             $signed(m_tdata[dwgs_pkg::VAL_W-1:0]), m_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        t_ripple_result                    typed_res;
        int                                pick;
        logic [1:0]                        act;
        logic signed [dwgs_pkg::VAL_W-1:0] h;

        for (int i = 0; i < dwgs_pkg::CELLS; i++) begin
            model_height[i] = '0;
            model_velocity[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Rows below eight hold a checkerboard of extremes so that the sums
        // and the velocity saturate; the rest is random.
        calm = 1'b1;
        for (int i = 0; i < dwgs_pkg::CELLS; i++) begin
            if (i < 8 * dwgs_pkg::GRID_WIDTH) begin
                h = ((i / dwgs_pkg::GRID_WIDTH + i) % 2) ? H_MAX : H_MIN;
            end else if ($urandom_range(0, 3) == 0) begin
                h = dwgs_pkg::VAL_W'($urandom);
            end else begin
                h = dwgs_pkg::VAL_W'($signed($urandom_range(0, 4095)) - 2048);
            end
            send_request(dwgs_pkg::ACT_WRITE, dwgs_pkg::ROW_W'(i / dwgs_pkg::GRID_WIDTH),
                         dwgs_pkg::COL_W'(i % dwgs_pkg::GRID_WIDTH), h, 1'b0, typed_res);
        end
        calm = 1'b0;

        foreach (directed[k]) begin
            typed_res.height = directed[k].exp_height;
            typed_res.done = directed[k].exp_done;
            send_request(directed[k].act, directed[k].row, directed[k].col,
                         directed[k].height, directed[k].typed, typed_res);
        end
        release_stream();

        for (int p = 0; p < 5; p++) begin
            set_damping(p == 3 ? dwgs_pkg::DAMP_W'($urandom) : phase_damping[p]);
            calm = (p == 2);
            for (int n = 0; n < 20; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 9 && steps_run < MAX_STEPS) begin
                    act = dwgs_pkg::ACT_STEP;
                end else if (pick < 50) begin
                    act = dwgs_pkg::ACT_READ;
                end else if (pick < 95) begin
                    act = dwgs_pkg::ACT_WRITE;
                end else begin
                    act = ACT_IGNORED;
                end
                case ($urandom_range(0, 3))
                    0: h = H_MAX;
                    1: h = H_MIN;
                    default: h = dwgs_pkg::VAL_W'($urandom);
                endcase
                send_request(act, dwgs_pkg::ROW_W'($urandom), dwgs_pkg::COL_W'($urandom), h,
                             1'b0, typed_res);
            end
            if (steps_run < MAX_STEPS) begin
                send_request(dwgs_pkg::ACT_STEP, '0, '0, '0, 1'b0, typed_res);
            end
            send_request(dwgs_pkg::ACT_READ, dwgs_pkg::ROW_W'($urandom_range(1, 62)),
                         dwgs_pkg::COL_W'($urandom_range(1, 62)), '0, 1'b0, typed_res);
            release_stream();
        end
        calm = 1'b0;

        wait (pending_results.size() == 0);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("damped_wave_grid_step_tb: clean");
        end else begin
            $display("damped_wave_grid_step_tb: errors");
        end
        $finish;
    end

endmodule
